>>> src/raf_pkg.sv
// Shared types and constants for the rolling average filter.
package raf_pkg;

  // Port widths of the payload fields.
  localparam int SAMPLE_W = 12;
  localparam int AVG_W    = 12;

  // Defaults for the top-level parameters.
  localparam int DEF_WINDOW_DEPTH = 16;
  localparam int DEF_SAMPLE_BITS  = 12;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIVIDE,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch sample, read the oldest entry
    logic update;    // retire oldest entry, store sample, seed divider
    logic step;      // one restoring-division step
    logic load_out;  // move quotient into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_step; // the current division step is the final one
  } status_t;

endpackage

>>> src/raf_dp.sv
// Datapath: sample ring, running sum, write position and bit-serial divider.
module raf_dp #(
  parameter int WINDOW_DEPTH = 16,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  raf_pkg::cmd_t                 cmd,
  output raf_pkg::status_t              status,
  input  logic [raf_pkg::SAMPLE_W-1:0]  sample,
  output logic [raf_pkg::AVG_W-1:0]     average,
  output logic                          window_full
);
  import raf_pkg::*;

  localparam int PW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W = SAMPLE_BITS + PW;
  localparam int DIV_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CNT_W = $clog2(SAMPLE_BITS);

  logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] samp;
  logic [SUM_W-1:0]       running_sum;
  logic [SUM_W-1:0]       running_sum_next;
  logic [PW-1:0]          write_position;
  logic [PW-1:0]          write_position_next;
  logic                   filled_once;
  logic                   wrap;
  logic [DIV_W-1:0]       divisor;
  logic [DIV_W-1:0]       divisor_next;
  logic [DIV_W-1:0]       rem;
  logic [SAMPLE_BITS-1:0] quot;
  logic [CNT_W-1:0]       cnt;
  logic [SAMPLE_BITS-1:0] old_value;
  logic [DIV_W:0]         rem_sh;
  logic [DIV_W:0]         rem_diff;
  logic                   q_bit;

  // An entry is only read before the first wrap if it was never written: it is zero.
  assign old_value = filled_once ? rd_data : '0;

  assign running_sum_next = running_sum - SUM_W'(old_value) + SUM_W'(samp);
  assign wrap             = (write_position == PW'(WINDOW_DEPTH - 1));
  assign write_position_next = wrap ? '0 : write_position + PW'(1);
  assign divisor_next = (filled_once || wrap) ? DIV_W'(WINDOW_DEPTH)
                                              : DIV_W'(write_position) + DIV_W'(1);

  assign rem_sh   = {rem, quot[SAMPLE_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign q_bit    = (rem_sh >= {1'b0, divisor});

  assign status.last_step = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp    <= SAMPLE_BITS'(sample);
      rd_data <= mem[write_position];
    end
    if (cmd.update) begin
      mem[write_position] <= samp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      write_position <= '0;
      filled_once    <= 1'b0;
    end else if (cmd.update) begin
      running_sum    <= running_sum_next;
      write_position <= write_position_next;
      if (wrap) begin
        filled_once <= 1'b1;
      end
    end
  end

  // Seed the remainder with the sum's high part: it is already below the divisor.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      divisor <= divisor_next;
      rem     <= DIV_W'(running_sum_next[SUM_W-1:SAMPLE_BITS]);
      quot    <= running_sum_next[SAMPLE_BITS-1:0];
      cnt     <= CNT_W'(SAMPLE_BITS - 1);
    end else if (cmd.step) begin
      rem  <= q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quot <= {quot[SAMPLE_BITS-2:0], q_bit};
      cnt  <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average     <= AVG_W'(quot);
      window_full <= filled_once;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> divisor != '0)
    else $error("divide step with zero divisor");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> rem < divisor)
    else $error("remainder not below divisor");

endmodule

>>> src/raf_ctrl.sv
// Controller: sequences capture, update, division and output handoff.
module raf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output raf_pkg::cmd_t    cmd,
  input  raf_pkg::status_t status
);
  import raf_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_UPDATE;
      S_UPDATE: state_next = S_DIVIDE;
      S_DIVIDE: if (status.last_step) state_next = S_OUT;
      S_OUT:    if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_UPDATE: cmd.update = 1'b1;
      S_DIVIDE: cmd.step   = 1'b1;
      S_OUT:    cmd.load_out = slot_free;
      default:  cmd = '0;
    endcase
  end

  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_UPDATE)
    else $error("accepted beat not followed by update");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> slot_free)
    else $error("output register overwritten while full");

endmodule

>>> src/rolling_average_filter_core.sv
// Top level of the rolling average filter: controller plus datapath.
//
//   channel  direction  handshake             payload
//   in       into core  in_valid / in_ready   sample[11:0]
//   out      from core  out_valid / out_ready average[11:0], window_full
//
// Each input beat passes through these steps before the next beat is accepted:
// capture and read the oldest ring entry, update the running sum and ring,
// SAMPLE_BITS restoring-division steps (one quotient bit per cycle), and
// hand the quotient to the output register.
// The output register holds a finished result while the next beat is taken;
// a stalled out_ready only blocks the core once a second result is ready.
// Reset (rst, synchronous) clears the sum, write position and wrap flag; the
// ring itself needs no clearing pass, since before the first wrap every entry
// being retired was never written and is read as zero.
module rolling_average_filter_core #(
  parameter int WINDOW_DEPTH = raf_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = raf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [raf_pkg::SAMPLE_W-1:0]  sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [raf_pkg::AVG_W-1:0]     average,
  output logic                          window_full
);
  import raf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the beat through capture, update, divide and output.
  raf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Hold the ring, running sum and the serial divider.
  raf_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (sample),
    .average     (average),
    .window_full (window_full)
  );

endmodule
